// File: rtl/aaac_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the atomic ALU admission check.
// No dependencies; imported by every module of the block.
package aaac_pkg;

    // Record store geometry
    localparam int MAX_RECORDS = 64;
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

    // Field widths
    localparam int ADDR_W  = 64;
    localparam int TICK_W  = 48;
    localparam int ALU_W   = 7;
    localparam int LAT_W   = 16;
    localparam int SHIFT_W = 4;
    localparam int CAUSE_W = 2;
    localparam int CIDX_W  = 2;
    localparam int CDAT_W  = 16;
    localparam int CMP_W   = (CNT_W > ALU_W) ? CNT_W : ALU_W;

    // Operation codes
    localparam logic OP_CHECK   = 1'b0;
    localparam logic OP_RESERVE = 1'b1;

    // Refusal causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE       = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_ALU_LIMIT  = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_LINE_BUSY  = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_STORE_FULL = 2'd3;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_NUM_ALUS    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_ACCESS_LAT  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_LINE_OFFSET = 2'd2;

    // Reset values of the configuration registers
    localparam logic [ALU_W-1:0]   RST_NUM_ALUS    = 7'd4;
    localparam logic [LAT_W-1:0]   RST_ACCESS_LAT  = 16'd4;
    localparam logic [SHIFT_W-1:0] RST_LINE_OFFSET = 4'd6;

    // Beat that sweeps down the chain of record cells
    typedef struct packed {
        logic              valid;
        logic              op;
        logic [ADDR_W-1:0] line;
        logic [TICK_W-1:0] now_tick;
        logic [TICK_W-1:0] oldest;
        logic              can_expire;
        logic [CNT_W-1:0]  started;
        logic              busy;
        logic              found;
    } t_sweep;

endpackage

// File: rtl/aaac_cell.sv
`timescale 1ns / 1ps
// One record cell: holds a single reservation and updates the sweep beat.
// Depends on aaac_pkg.
module aaac_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  aaac_pkg::t_sweep i_sweep,
    output aaac_pkg::t_sweep o_sweep
);
    import aaac_pkg::*;

    logic              r_live;
    logic [ADDR_W-1:0] r_line;
    logic [TICK_W-1:0] r_start;
    t_sweep            r_sweep;
    t_sweep            n_sweep;
    logic              n_live;
    logic              expire_hit;
    logic              live_eff;
    logic              take_slot;

    // Expire on a check beat, then count and match against the live record
    always_comb begin
        expire_hit = i_sweep.valid && (i_sweep.op == OP_CHECK) && r_live &&
                     i_sweep.can_expire && (r_start < i_sweep.oldest);
        live_eff   = r_live && !expire_hit;
        take_slot  = i_sweep.valid && (i_sweep.op == OP_RESERVE) &&
                     !i_sweep.found && !r_live;
        n_sweep    = i_sweep;
        n_live     = live_eff;
        if (i_sweep.valid && (i_sweep.op == OP_CHECK) && live_eff) begin
            if (r_start == i_sweep.now_tick) begin
                n_sweep.started = i_sweep.started + CNT_W'(1);
            end
            if (r_line == i_sweep.line) begin
                n_sweep.busy = 1'b1;
            end
        end
        if (take_slot) begin
            n_sweep.found = 1'b1;
            n_live        = 1'b1;
        end
    end

    // Hold the live bit and the beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live  <= 1'b0;
            r_sweep <= '0;
        end else begin
            r_live  <= n_live;
            r_sweep <= n_sweep;
        end
    end

    // Store the record payload on a reserve that lands here
    always_ff @(posedge i_clk) begin
        if (take_slot) begin
            r_line  <= i_sweep.line;
            r_start <= i_sweep.now_tick;
        end
    end

    assign o_sweep = r_sweep;

endmodule

// File: rtl/aaac_ctrl.sv
`timescale 1ns / 1ps
// Control: configuration registers, input beat launch into the cell chain,
// and the result decision and output register. Depends on aaac_pkg.
module aaac_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_operation,
    input  logic [aaac_pkg::ADDR_W-1:0]   i_address,
    input  logic [aaac_pkg::TICK_W-1:0]   i_now_tick,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_granted,
    output logic [aaac_pkg::CAUSE_W-1:0]  o_refusal_cause,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [aaac_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [aaac_pkg::CDAT_W-1:0]   i_cfg_data,
    output aaac_pkg::t_sweep              o_head,
    input  aaac_pkg::t_sweep              i_tail
);
    import aaac_pkg::*;

    logic [ALU_W-1:0]   r_num_alus;
    logic [LAT_W-1:0]   r_access_lat;
    logic [SHIFT_W-1:0] r_line_offset;

    logic               r_active;
    logic               r_pend;
    logic               r_pend_granted;
    logic [CAUSE_W-1:0] r_pend_cause;
    logic               r_out_valid;
    logic               r_out_granted;
    logic [CAUSE_W-1:0] r_out_cause;
    t_sweep             r_head;

    logic               in_fire;
    logic               out_free;
    logic [ADDR_W-1:0]  line_mask;
    logic [TICK_W-1:0]  lat_ext;
    t_sweep             n_head;
    logic               res_granted;
    logic [CAUSE_W-1:0] res_cause;

    assign in_fire     = i_valid && o_ready;
    assign out_free    = !r_out_valid || i_ready;
    assign o_ready     = !r_active && !r_pend;
    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_alus    <= RST_NUM_ALUS;
            r_access_lat  <= RST_ACCESS_LAT;
            r_line_offset <= RST_LINE_OFFSET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NUM_ALUS:    r_num_alus    <= i_cfg_data[ALU_W-1:0];
                CFG_ACCESS_LAT:  r_access_lat  <= i_cfg_data[LAT_W-1:0];
                CFG_LINE_OFFSET: r_line_offset <= i_cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // Form the launch beat: line address, expiry bound
    always_comb begin
        line_mask         = ~((ADDR_W'(1) << r_line_offset) - ADDR_W'(1));
        lat_ext           = TICK_W'(r_access_lat);
        n_head            = '0;
        n_head.valid      = in_fire;
        n_head.op         = i_operation;
        n_head.line       = i_address & line_mask;
        n_head.now_tick   = i_now_tick;
        n_head.oldest     = i_now_tick - lat_ext;
        n_head.can_expire = (i_now_tick >= lat_ext);
    end

    // Decide the result from the beat leaving the last cell
    always_comb begin
        res_granted = 1'b0;
        res_cause   = CAUSE_NONE;
        if (i_tail.op == OP_CHECK) begin
            priority if (CMP_W'(i_tail.started) >= CMP_W'(r_num_alus)) begin
                res_cause = CAUSE_ALU_LIMIT;
            end else if (i_tail.busy) begin
                res_cause = CAUSE_LINE_BUSY;
            end else begin
                res_granted = 1'b1;
            end
        end else begin
            if (i_tail.found) begin
                res_granted = 1'b1;
            end else begin
                res_cause = CAUSE_STORE_FULL;
            end
        end
    end

    // Advance control: launch, park result, hand to output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_active    <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head <= n_head;
            if (in_fire) begin
                r_active <= 1'b1;
            end else if (i_tail.valid) begin
                r_active <= 1'b0;
            end
            if (i_tail.valid) begin
                r_pend <= 1'b1;
            end else if (r_pend && out_free) begin
                r_pend <= 1'b0;
            end
            if (r_pend && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold result payloads
    always_ff @(posedge i_clk) begin
        if (i_tail.valid) begin
            r_pend_granted <= res_granted;
            r_pend_cause   <= res_cause;
        end
        if (r_pend && out_free) begin
            r_out_granted <= r_pend_granted;
            r_out_cause   <= r_pend_cause;
        end
    end

    assign o_head          = r_head;
    assign o_valid         = r_out_valid;
    assign o_granted       = r_out_granted;
    assign o_refusal_cause = r_out_cause;

endmodule

// File: rtl/atomic_alu_admission_check_core.sv
`timescale 1ns / 1ps
// Admission check for pipelined atomic ALUs: a chain of MAX_RECORDS record
// cells swept once per item. An input beat passes the launch register (loaded at
// the accepting edge), then each record cell register in turn, then the park
// register and the output register. The block takes no new item until the last
// one has left the chain and its parked result has moved to the output register;
// a stalled output beat holds off the next input beat. Reset clears all live
// bits and config to defaults.
module atomic_alu_admission_check_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_operation,
    input  logic [aaac_pkg::ADDR_W-1:0]   i_address,
    input  logic [aaac_pkg::TICK_W-1:0]   i_now_tick,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_granted,
    output logic [aaac_pkg::CAUSE_W-1:0]  o_refusal_cause,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [aaac_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [aaac_pkg::CDAT_W-1:0]   i_cfg_data
);
    import aaac_pkg::*;

    t_sweep chain [MAX_RECORDS+1];

    // Control and result path
    aaac_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_address       (i_address),
        .i_now_tick      (i_now_tick),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_granted       (o_granted),
        .o_refusal_cause (o_refusal_cause),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_head          (chain[0]),
        .i_tail          (chain[MAX_RECORDS])
    );

    // Record cells, lowest slot first
    for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
        aaac_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_sweep (chain[g]),
            .o_sweep (chain[g+1])
        );
    end

endmodule

// File: verif/tb_atomic_alu_admission_check_core.sv
`timescale 1ns / 1ps
// Testbench for atomic_alu_admission_check_core: directed and random admission traffic,
// every result beat checked against a behavioral model of the reservation store.
// Depends on aaac_pkg and the core RTL.
module tb_atomic_alu_admission_check_core;
    import aaac_pkg::*;

    localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int PIPE_LAT = MAX_RECORDS + 3;
    localparam int MAX_SHOWN = 10;
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
    localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

    typedef struct packed {
        logic               granted;
        logic [CAUSE_W-1:0] cause;
    } t_decision;

    // DUT-facing signals
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               in_op = OP_CHECK;
    logic [ADDR_W-1:0]  in_addr = '0;
    logic [TICK_W-1:0]  in_tick = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               out_granted;
    logic [CAUSE_W-1:0] out_cause;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index = '0;
    logic [CDAT_W-1:0]  cfg_data = '0;

    // Shadow copy of the reservation store and its registers
    logic [ADDR_W-1:0]  rec_line [MAX_RECORDS];
    logic [TICK_W-1:0]  rec_start [MAX_RECORDS];
    logic               rec_live [MAX_RECORDS];
    logic [ALU_W-1:0]   shadow_alus;
    logic [LAT_W-1:0]   shadow_lat;
    logic [SHIFT_W-1:0] shadow_shift;

    t_decision decision_q [$];
    bit        in_held = 1'b0;
    bit        no_stall = 1'b0;
    int        mismatches = 0;
    int        items_sent = 0;
    int        results_seen = 0;
    int        grants_seen = 0;
    int        cause_seen [4] = '{0, 0, 0, 0};

    atomic_alu_admission_check_core uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_ready         (in_ready),
        .i_operation     (in_op),
        .i_address       (in_addr),
        .i_now_tick      (in_tick),
        .o_valid         (out_valid),
        .i_ready         (out_ready),
        .o_granted       (out_granted),
        .o_refusal_cause (out_cause),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expire, count and match, or store a record; returns the decision the core should make
    function automatic t_decision admission_decide(logic op, logic [ADDR_W-1:0] addr,
                                                   logic [TICK_W-1:0] tick);
        t_decision         d;
        logic [ADDR_W-1:0] line_addr;
        logic [TICK_W-1:0] oldest;
        int                started;
        logic              busy;
        int                slot;
        d         = '0;
        line_addr = (addr >> shadow_shift) << shadow_shift;
        started   = 0;
        busy      = 1'b0;
        slot      = -1;
        if (op == OP_CHECK) begin
            // nothing expires while the clock is still below the latency
            if (tick >= TICK_W'(shadow_lat)) begin
                oldest = tick - TICK_W'(shadow_lat);
                for (int i = 0; i < MAX_RECORDS; i++) begin
                    if (rec_live[i] && rec_start[i] < oldest) rec_live[i] = 1'b0;
                end
            end
            for (int i = 0; i < MAX_RECORDS; i++) begin
                if (rec_live[i]) begin
                    if (rec_start[i] == tick) started++;
                    if (rec_line[i] == line_addr) busy = 1'b1;
                end
            end
            // the ALU limit wins when both reasons apply
            if (started >= int'(shadow_alus)) d.cause = CAUSE_ALU_LIMIT;
            else if (busy) d.cause = CAUSE_LINE_BUSY;
            else d.granted = 1'b1;
        end else begin
            for (int i = 0; i < MAX_RECORDS; i++) begin
                if (!rec_live[i] && slot < 0) slot = i;
            end
            if (slot < 0) begin
                d.cause = CAUSE_STORE_FULL;
            end else begin
                rec_line[slot]  = line_addr;
                rec_start[slot] = tick;
                rec_live[slot]  = 1'b1;
                d.granted       = 1'b1;
            end
        end
        return d;
    endfunction

    task automatic reset_shadow();
        for (int i = 0; i < MAX_RECORDS; i++) begin
            rec_line[i]  = '0;
            rec_start[i] = '0;
            rec_live[i]  = 1'b0;
        end
        shadow_alus  = RST_NUM_ALUS;
        shadow_lat   = RST_ACCESS_LAT;
        shadow_shift = RST_LINE_OFFSET;
    endtask

    // Send one request beat after a random gap; predict its decision once accepted
    task automatic send_item(input logic op, input logic [ADDR_W-1:0] addr,
                             input logic [TICK_W-1:0] tick, output t_decision d);
        int gap;
        gap = no_stall ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            if (in_held) begin
                in_valid <= 1'b0;
                in_held = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_held = 1'b1;
        in_op   <= op;
        in_addr <= addr;
        in_tick <= tick;
        do @(posedge clk); while (!in_ready);
        d = admission_decide(op, addr, tick);
        decision_q.push_back(d);
        items_sent++;
    endtask

    // Drop the request valid and hold until every predicted decision has come back
    task automatic wait_drain();
        if (in_held) begin
            in_valid <= 1'b0;
            in_held = 1'b0;
        end
        while (decision_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_NUM_ALUS:    shadow_alus  = data[ALU_W-1:0];
            CFG_ACCESS_LAT:  shadow_lat   = data[LAT_W-1:0];
            CFG_LINE_OFFSET: shadow_shift = data[SHIFT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CDAT_W-1:0] alus, input logic [CDAT_W-1:0] lat,
                              input logic [CDAT_W-1:0] shift);
        wait_drain();
        write_reg(CFG_NUM_ALUS, alus);
        write_reg(CFG_ACCESS_LAT, lat);
        write_reg(CFG_LINE_OFFSET, shift);
        cfg_valid <= 1'b0;
    endtask

    // Reset registers: grant, line busy, ALU limit, both reasons, expiry boundary
    task automatic test_default_limits();
        t_decision d;
        send_item(OP_CHECK,   64'h1000, 48'd100, d);
        send_item(OP_RESERVE, 64'h1000, 48'd100, d);
        send_item(OP_CHECK,   64'h103F, 48'd100, d);
        send_item(OP_CHECK,   64'h2000, 48'd100, d);
        send_item(OP_RESERVE, 64'h2000, 48'd100, d);
        send_item(OP_RESERVE, 64'h3000, 48'd100, d);
        send_item(OP_RESERVE, 64'h4000, 48'd100, d);
        send_item(OP_CHECK,   64'h5000, 48'd100, d);
        send_item(OP_CHECK,   64'h1000, 48'd100, d);
        send_item(OP_CHECK,   64'h1000, 48'd104, d);
        send_item(OP_CHECK,   64'h1000, 48'd105, d);
    endtask

    // Address and tick extremes, time going backwards, clock below latency, zero latency
    task automatic test_field_extremes();
        t_decision d;
        set_config(16'd64, 16'hFFFF, 16'd0);
        send_item(OP_RESERVE, ADDR_MAX, TICK_MAX, d);
        send_item(OP_RESERVE, 64'h0, 48'd0, d);
        send_item(OP_CHECK,   ADDR_MAX, 48'd5, d);
        send_item(OP_CHECK,   64'h0, 48'd0, d);
        send_item(OP_CHECK,   64'h1, 48'd0, d);
        send_item(OP_CHECK,   64'h0, TICK_MAX, d);
        set_config(16'd1, 16'd0, 16'd12);
        send_item(OP_RESERVE, 64'hABCD_0000_0000_1234, 48'd50, d);
        send_item(OP_CHECK,   64'h5555_0000_0000_0000, 48'd50, d);
        send_item(OP_CHECK,   64'hABCD_0000_0000_1FFF, 48'd51, d);
    endtask

    // Zero ALUs refuses every check; upper data bits are dropped by the register
    task automatic test_zero_alus();
        t_decision d;
        set_config(16'hFF80, 16'd4, 16'd6);
        send_item(OP_CHECK,   64'h9000, 48'd10, d);
        send_item(OP_RESERVE, 64'h9000, 48'd10, d);
        send_item(OP_CHECK,   64'hA000, 48'd11, d);
    endtask

    // Widest line offset (15) and an offset of 12
    task automatic test_line_offsets();
        t_decision d;
        set_config(16'd4, 16'd100, 16'hFFFF);
        send_item(OP_RESERVE, 64'h7FFF, 48'd10, d);
        send_item(OP_CHECK,   64'h0000, 48'd10, d);
        send_item(OP_CHECK,   64'h8000, 48'd10, d);
        set_config(16'd4, 16'd100, 16'd12);
        send_item(OP_CHECK,   64'h0FFF, 48'd11, d);
        send_item(OP_CHECK,   64'h1000, 48'd11, d);
    endtask

    // A write to an index past the register list must change nothing
    task automatic test_unused_register();
        t_decision d;
        wait_drain();
        write_reg(CFG_UNUSED, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_item(OP_CHECK, 64'h2_0000, 48'd12, d);
        send_item(OP_CHECK, 64'h0FFF, 48'd12, d);
    endtask

    // Fill every slot, overflow, then free the store by expiry
    task automatic test_store_full();
        t_decision d;
        set_config(16'd64, 16'hFFFF, 16'd6);
        for (int i = 0; i < MAX_RECORDS + 2; i++) begin
            send_item(OP_RESERVE, {$urandom, $urandom}, 48'd1000, d);
        end
        send_item(OP_CHECK,   64'h4_0000, 48'd300000, d);
        send_item(OP_RESERVE, 64'h4_0000, 48'd300000, d);
    endtask

    // Phases of random settings: mostly check-then-reserve requests, some noise
    task automatic test_random_traffic();
        t_decision         d;
        logic [ADDR_W-1:0] pool [6];
        logic [ADDR_W-1:0] addr;
        logic [TICK_W-1:0] tick;
        logic [6:0]        alus;
        logic [15:0]       lat;
        logic [3:0]        shift;
        int                n;
        bit                drained;
        drained = 1'b0;
        for (int phase = 0; phase < 12; phase++) begin
            case ($urandom_range(0, 3))
                0: alus = 7'd1;
                1: alus = 7'd64;
                2: alus = 7'($urandom_range(1, 4));
                default: alus = 7'($urandom_range(0, 127));
            endcase
            case ($urandom_range(0, 3))
                0: lat = 16'd0;
                1: lat = 16'hFFFF;
                2: lat = 16'($urandom_range(1, 8));
                default: lat = 16'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0: shift = 4'd0;
                1: shift = 4'd12;
                2: shift = 4'd15;
                default: shift = 4'($urandom_range(0, 12));
            endcase
            set_config({9'($urandom), alus}, lat, {12'($urandom), shift});
            no_stall = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0: tick = TICK_W'($urandom_range(0, 100));
                1: tick = TICK_W'({$urandom, $urandom});
                default: tick = TICK_MAX - TICK_W'($urandom_range(0, 200));
            endcase
            for (int i = 0; i < 6; i++) pool[i] = {$urandom, $urandom};
            n = 0;
            while (n < 54) begin
                // hold off new requests once until the pipeline is empty
                if (phase == 5 && n >= 30 && !drained) begin
                    wait_drain();
                    drained = 1'b1;
                end
                if ($urandom_range(0, 3) != 0) begin
                    addr = pool[$urandom_range(0, 5)] ^ ADDR_W'($urandom_range(0, 4095));
                    send_item(OP_CHECK, addr, tick, d);
                    n++;
                    if (d.granted) begin
                        send_item(OP_RESERVE, addr, tick, d);
                        n++;
                    end
                    case ($urandom_range(0, 7))
                        0, 1, 2: ;
                        3: tick = tick + TICK_W'(lat) + 1'b1;
                        default: tick = tick + TICK_W'($urandom_range(1, 3));
                    endcase
                end else begin
                    addr = {$urandom, $urandom};
                    send_item(logic'($urandom_range(0, 1)), addr,
                              ($urandom_range(0, 1) == 0) ? tick : TICK_W'({$urandom, $urandom}),
                              d);
                    n++;
                end
            end
        end
        no_stall = 1'b0;
    endtask

    // Result side: random stall per beat, compare each beat with the oldest prediction
    initial begin
        int        stall;
        t_decision got;
        t_decision want;
        wait (rst_n);
        forever begin
            stall = no_stall ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.granted = out_granted;
            got.cause   = out_cause;
            results_seen++;
            if (got.granted === 1'b1) grants_seen++;
            else if (!$isunknown(got.cause)) cause_seen[got.cause]++;
            if (decision_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result beat: granted %0b cause %0d",
                             got.granted, got.cause);
            end else begin
                want = decision_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display({"mismatch on result %0d: granted exp %0b got %0b,",
                                  " cause exp %0d got %0d"},
                                 results_seen, want.granted, got.granted, want.cause,
                                 got.cause);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        reset_shadow();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_default_limits();
        test_field_extremes();
        test_zero_alus();
        test_line_offsets();
        test_unused_register();
        test_store_full();
        test_random_traffic();
        wait_drain();
        repeat (2 * PIPE_LAT) @(posedge clk);
        $display("ran %0d requests, %0d decisions: %0d granted, %0d ALU limit,",
                 items_sent, results_seen, grants_seen, cause_seen[CAUSE_ALU_LIMIT]);
        $display("%0d line busy, %0d store full, %0d mismatching or unexpected decisions",
                 cause_seen[CAUSE_LINE_BUSY], cause_seen[CAUSE_STORE_FULL], mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/aaac_pkg.sv
rtl/aaac_cell.sv
rtl/aaac_ctrl.sv
rtl/atomic_alu_admission_check_core.sv
verif/tb_atomic_alu_admission_check_core.sv
